// ----- rtl/sta_pkg.sv -----
`default_nettype none
package sta_pkg;
  localparam int unsigned MapEntries = 64;
  localparam int unsigned AddrBits   = 16;
  localparam int unsigned SizeBits   = AddrBits + 1;
  localparam int unsigned OwnBits    = 8;
  localparam int unsigned IdxBits    = $clog2(MapEntries);
  localparam int unsigned CntBits    = IdxBits + 1;

  localparam logic [1:0] ReqAlloc   = 2'd0;
  localparam logic [1:0] ReqRelease = 2'd1;
  localparam logic [1:0] ReqInit    = 2'd2;

  localparam logic [1:0] PolFirst = 2'd0;
  localparam logic [1:0] PolBest  = 2'd1;
  localparam logic [1:0] PolWorst = 2'd2;
  localparam logic [1:0] PolNext  = 2'd3;

  localparam logic [1:0] StDone     = 2'd0;
  localparam logic [1:0] StNoFit    = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;
  localparam logic [1:0] StNotFound = 2'd3;

  typedef struct packed {
    logic [AddrBits-1:0] start;
    logic [AddrBits-1:0] last;
    logic [SizeBits-1:0] size;
    logic [OwnBits-1:0]  owner;
  } seg_t;

  // controller -> datapath
  typedef enum logic [3:0] {
    OpNone  = 4'b0001,
    OpRead  = 4'b0010,
    OpWrite = 4'b0100,
    OpCount = 4'b1000
  } dp_op_e;

  typedef struct packed {
    dp_op_e              op;
    logic [IdxBits-1:0]  raddr;
    logic [IdxBits-1:0]  waddr;
    seg_t                wdata;
    logic [CntBits-1:0]  count;
  } dp_cmd_t;

  typedef struct packed {
    seg_t               rdata;
    logic [CntBits-1:0] count;
  } dp_sts_t;
endpackage
`default_nettype wire

// ----- rtl/sta_datapath.sv -----
`default_nettype none
module sta_datapath import sta_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire dp_cmd_t cmd_i,
  output dp_sts_t      sts_o
);
  seg_t               mem_q [MapEntries];
  seg_t               rdata_q;
  logic [CntBits-1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OpWrite) begin
      mem_q[cmd_i.waddr] <= cmd_i.wdata;
    end
    rdata_q <= mem_q[cmd_i.raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.op == OpCount) begin
      count_q <= cmd_i.count;
    end
  end

  assign sts_o.rdata = rdata_q;
  assign sts_o.count = count_q;
endmodule
`default_nettype wire

// ----- rtl/sta_ctrl.sv -----
`default_nettype none
module sta_ctrl import sta_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [1:0]          req_type_i,
  input  wire logic [SizeBits-1:0] request_size_i,
  input  wire logic [OwnBits-1:0]  owner_id_i,
  input  wire logic [AddrBits-1:0] last_start_address_i,
  input  wire logic [1:0]          fit_policy_i,
  input  wire logic [SizeBits-1:0] memory_size_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [AddrBits-1:0]      block_start_o,
  output logic [AddrBits-1:0]      block_end_o,
  output logic [SizeBits-1:0]      block_size_o,
  output logic [OwnBits-1:0]       block_owner_o,
  output logic [1:0]               status_o,
  output dp_cmd_t                  cmd_o,
  input  wire dp_sts_t             sts_i
);
  typedef enum logic [10:0] {
    SIdle   = 11'b00000000001,
    SScan   = 11'b00000000010, // issue read i
    SScanW  = 11'b00000000100, // data of i
    SDecide = 11'b00000001000,
    SShiftR = 11'b00000010000, // read src for move
    SShiftW = 11'b00000100000, // write dst
    SFix    = 11'b00001000000, // final entry writes
    SNbrR   = 11'b00010000000, // neighbour reads
    SNbrW   = 11'b00100000000,
    SFix2   = 11'b01000000000,
    SOut    = 11'b10000000000
  } state_e;

  state_e               state_q, state_d;
  logic [1:0]           typ_q;
  logic [SizeBits-1:0]  req_q;
  logic [OwnBits-1:0]   own_q;
  logic [AddrBits-1:0]  last_q;
  logic [CntBits-1:0]   i_q, i_d;
  logic [CntBits-1:0]   pick_q, pick_d;
  logic                 found_q, found_d;
  logic                 seen_q, seen_d;
  seg_t                 pseg_q, pseg_d;   // picked or released entry
  seg_t                 lseg_q, lseg_d;   // left neighbour
  seg_t                 rseg_q, rseg_d;   // right neighbour
  logic [1:0]           nstep_q, nstep_d;
  logic                 rdone_q, rdone_d;
  logic [1:0]           mode_q, mode_d;   // 0 split, 1..2 remove n
  logic [CntBits-1:0]   fix_q, fix_d;
  logic                 ov_q, ov_d;
  logic [AddrBits-1:0]  os_q, os_d, oe_q, oe_d;
  logic [SizeBits-1:0]  oz_q, oz_d;
  logic [OwnBits-1:0]   oo_q, oo_d;
  logic [1:0]           ost_q, ost_d;
  logic                 acc;
  logic [CntBits-1:0]   cnt;
  seg_t                 rd;
  logic                 fit;
  logic [SizeBits:0]    msz;
  logic                 lf, rf;

  assign cnt = sts_i.count;
  assign rd  = sts_i.rdata;
  assign acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != SIdle) || ov_q;
  assign fit = (rd.owner == '0) && (rd.size >= req_q);
  assign lf = (pick_q != '0) && (lseg_q.owner == '0);
  assign rf = (pick_q + 1'b1 < cnt) && (rseg_q.owner == '0);

  always_comb begin
    state_d = state_q; i_d = i_q; pick_d = pick_q; found_d = found_q;
    seen_d = seen_q; pseg_d = pseg_q; lseg_d = lseg_q; rseg_d = rseg_q;
    nstep_d = nstep_q; rdone_d = rdone_q; mode_d = mode_q; fix_d = fix_q;
    ov_d = ov_q && out_stall_i; os_d = os_q; oe_d = oe_q; oz_d = oz_q;
    oo_d = oo_q; ost_d = ost_q;
    msz = '0;
    cmd_o = '{op: OpNone, raddr: i_q[IdxBits-1:0], waddr: '0, wdata: '0, count: '0};
    case (state_q)
      SIdle: begin
        if (acc) begin
          os_d = '0; oe_d = '0; oz_d = '0; oo_d = '0; ost_d = StDone;
          i_d = '0; found_d = 1'b0; seen_d = 1'b0; rdone_d = 1'b0;
          case (req_type_i)
            ReqAlloc: begin
              if (request_size_i == '0 || owner_id_i == '0) begin
                ost_d = StNoFit; state_d = SOut;
              end else begin
                state_d = SScan;
              end
            end
            ReqRelease: begin
              if (owner_id_i == '0) begin
                ost_d = StNotFound; state_d = SOut;
              end else begin
                state_d = SScan;
              end
            end
            ReqInit: begin
              msz = (memory_size_i > SizeBits'(1 << AddrBits)) ?
                    (SizeBits+1)'(1 << AddrBits) : {1'b0, memory_size_i};
              cmd_o.op = OpWrite; cmd_o.waddr = '0;
              cmd_o.wdata = '{start: '0, last: AddrBits'(msz - 1'b1),
                              size: msz[SizeBits-1:0], owner: '0};
              state_d = SFix2; fix_d = (msz == '0) ? '0 : CntBits'(1);
            end
            default: state_d = SOut;
          endcase
        end
      end
      SFix2: begin
        cmd_o.op = OpCount; cmd_o.count = fix_q; state_d = SOut;
      end
      SScan: begin
        if (i_q >= cnt) begin
          state_d = SDecide;
        end else begin
          cmd_o.op = OpRead; state_d = SScanW;
        end
      end
      SScanW: begin
        state_d = SScan; i_d = i_q + 1'b1;
        if (typ_q == ReqRelease) begin
          if (rd.owner == own_q) begin
            found_d = 1'b1; pick_d = i_q; pseg_d = rd; state_d = SDecide;
          end
        end else if (fit_policy_i == PolNext) begin
          if (rd.start == last_q) begin
            seen_d = 1'b1; found_d = 1'b0;
          end else if (seen_q && !found_q && fit) begin
            found_d = 1'b1; pick_d = i_q; pseg_d = rd;
          end
        end else if (fit) begin
          if (!found_q || (fit_policy_i == PolBest && rd.size < pseg_q.size) ||
              (fit_policy_i == PolWorst && rd.size > pseg_q.size)) begin
            found_d = 1'b1; pick_d = i_q; pseg_d = rd;
          end
          if (fit_policy_i == PolFirst) state_d = SDecide;
        end
      end
      SDecide: begin
        if (typ_q == ReqAlloc) begin
          if (!found_q) begin
            ost_d = StNoFit; state_d = SOut;
          end else if (pseg_q.size == req_q) begin
            cmd_o.op = OpWrite; cmd_o.waddr = pick_q[IdxBits-1:0];
            cmd_o.wdata = pseg_q; cmd_o.wdata.owner = own_q;
            os_d = pseg_q.start; oe_d = pseg_q.last; oz_d = pseg_q.size;
            oo_d = own_q; state_d = SOut;
          end else if (cnt >= CntBits'(MapEntries)) begin
            ost_d = StFull; state_d = SOut;
          end else begin
            mode_d = 2'd0; i_d = cnt; state_d = SShiftR;
          end
        end else begin
          if (!found_q) begin
            ost_d = StNotFound; state_d = SOut;
          end else begin
            nstep_d = 2'd0; state_d = SNbrR;
          end
        end
      end
      SNbrR: begin
        cmd_o.op = OpRead;
        cmd_o.raddr = (nstep_q == 2'd0) ? IdxBits'(pick_q - 1'b1) :
                                          IdxBits'(pick_q + 1'b1);
        state_d = SNbrW;
      end
      SNbrW: begin
        if (nstep_q == 2'd0) begin
          lseg_d = rd; nstep_d = 2'd1; state_d = SNbrR;
        end else begin
          rseg_d = rd; state_d = SFix;
        end
      end
      SFix: begin
        // release: write the merged or freed entry, then close any gap that a merge left
        cmd_o.op = OpWrite;
        if (lf && rf) begin
          cmd_o.waddr = IdxBits'(pick_q - 1'b1);
          cmd_o.wdata = lseg_q; cmd_o.wdata.last = rseg_q.last;
          cmd_o.wdata.size = lseg_q.size + pseg_q.size + rseg_q.size;
          mode_d = 2'd2; i_d = pick_q;
        end else if (lf) begin
          cmd_o.waddr = IdxBits'(pick_q - 1'b1);
          cmd_o.wdata = lseg_q; cmd_o.wdata.last = pseg_q.last;
          cmd_o.wdata.size = lseg_q.size + pseg_q.size;
          mode_d = 2'd1; i_d = pick_q;
        end else if (rf) begin
          cmd_o.waddr = pick_q[IdxBits-1:0];
          cmd_o.wdata = pseg_q; cmd_o.wdata.last = rseg_q.last;
          cmd_o.wdata.size = pseg_q.size + rseg_q.size; cmd_o.wdata.owner = '0;
          mode_d = 2'd1; i_d = pick_q + 1'b1;
        end else begin
          cmd_o.waddr = pick_q[IdxBits-1:0];
          cmd_o.wdata = pseg_q; cmd_o.wdata.owner = '0;
          mode_d = 2'd0;
        end
        state_d = (lf || rf) ? SShiftR : SOut;
      end
      SShiftR: begin
        if (mode_q == 2'd0) begin
          // split: move up from top down to pick+2
          if (i_q > pick_q + 1'b1) begin
            cmd_o.op = OpRead; cmd_o.raddr = IdxBits'(i_q - 1'b1); state_d = SShiftW;
          end else begin
            cmd_o.op = OpWrite; cmd_o.waddr = IdxBits'(pick_q + 1'b1);
            cmd_o.wdata = '{start: AddrBits'(pseg_q.start + req_q), last: pseg_q.last,
                            size: pseg_q.size - req_q, owner: '0};
            state_d = SShiftW; rdone_d = 1'b1;
          end
        end else begin
          if (i_q + mode_q < cnt) begin
            cmd_o.op = OpRead; cmd_o.raddr = IdxBits'(i_q + mode_q); state_d = SShiftW;
          end else begin
            cmd_o.op = OpCount; cmd_o.count = cnt - mode_q; state_d = SOut;
          end
        end
      end
      SShiftW: begin
        if (rdone_q) begin
          cmd_o.op = OpWrite; cmd_o.waddr = pick_q[IdxBits-1:0];
          cmd_o.wdata = '{start: pseg_q.start,
                          last: AddrBits'(pseg_q.start + req_q - 1'b1),
                          size: req_q, owner: own_q};
          os_d = pseg_q.start; oe_d = AddrBits'(pseg_q.start + req_q - 1'b1);
          oz_d = req_q; oo_d = own_q;
          state_d = SFix2; fix_d = cnt + 1'b1;
        end else begin
          cmd_o.op = OpWrite; cmd_o.waddr = i_q[IdxBits-1:0]; cmd_o.wdata = rd;
          i_d = (mode_q == 2'd0) ? i_q - 1'b1 : i_q + 1'b1;
          state_d = SShiftR;
        end
      end
      SOut: begin
        ov_d = 1'b1; state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      typ_q <= req_type_i; req_q <= request_size_i;
      own_q <= owner_id_i; last_q <= last_start_address_i;
    end
    i_q <= i_d; pick_q <= pick_d; found_q <= found_d; seen_q <= seen_d;
    pseg_q <= pseg_d; lseg_q <= lseg_d; rseg_q <= rseg_d; nstep_q <= nstep_d;
    rdone_q <= rdone_d; mode_q <= mode_d; fix_q <= fix_d;
    os_q <= os_d; oe_q <= oe_d; oz_q <= oz_d; oo_q <= oo_d; ost_q <= ost_d;
  end

  assign out_valid_o   = ov_q;
  assign block_start_o = os_q;
  assign block_end_o   = oe_q;
  assign block_size_o  = oz_q;
  assign block_owner_o = oo_q;
  assign status_o      = ost_q;
endmodule
`default_nettype wire

// ----- rtl/segment_table_allocator.sv -----
`default_nettype none
// Segment table allocator: first/best/worst/next fit over a 64-entry table.
// One request at a time: the input stalls until the result has been taken. Reset
// (async, active low) empties the table and sets fit_policy to first fit and
// memory_size to 65536; table contents stay.
module segment_table_allocator import sta_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [1:0]          req_type_i,
  input  wire logic [SizeBits-1:0] request_size_i,
  input  wire logic [OwnBits-1:0]  owner_id_i,
  input  wire logic [AddrBits-1:0] last_start_address_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [AddrBits-1:0]      block_start_o,
  output logic [AddrBits-1:0]      block_end_o,
  output logic [SizeBits-1:0]      block_size_o,
  output logic [OwnBits-1:0]       block_owner_o,
  output logic [1:0]               status_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic                cfg_index_i,
  input  wire logic [SizeBits-1:0] cfg_data_i
);
  logic [1:0]          fit_policy_q;
  logic [SizeBits-1:0] memory_size_q;
  dp_cmd_t             cmd;
  dp_sts_t             sts;

  // config always accepted; index 0 fit policy, index 1 memory size
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_policy_q  <= PolFirst;
      memory_size_q <= SizeBits'(1 << AddrBits);
    end else if (cfg_valid_i) begin
      if (!cfg_index_i) fit_policy_q <= cfg_data_i[1:0];
      else              memory_size_q <= cfg_data_i;
    end
  end

  sta_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .req_type_i, .request_size_i,
    .owner_id_i, .last_start_address_i,
    .fit_policy_i(fit_policy_q), .memory_size_i(memory_size_q),
    .out_valid_o, .out_stall_i, .block_start_o, .block_end_o, .block_size_o,
    .block_owner_o, .status_o, .cmd_o(cmd), .sts_i(sts)
  );

  sta_datapath u_dp (.clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts));
endmodule
`default_nettype wire

// ----- bench/tb_segment_table_allocator.sv -----
`timescale 1ns / 100ps
`default_nettype none

module tb_segment_table_allocator import sta_pkg::*;;

  // register indexes of the config port
  localparam logic CfgPolicy  = 1'b0;
  localparam logic CfgMemSize = 1'b1;

  // request code with no meaning, must leave the table alone
  localparam logic [1:0] ReqUnused = 2'd3;

  localparam int IdleLimit  = 5000;  // cycles with no handshake before giving up
  localparam int HoldCycles = 400;   // long receiver hold-off
  localparam int SettleWait = 300;   // settle time after the last drain, meant to outlast any request

  typedef struct {
    logic [AddrBits-1:0] start;
    logic [AddrBits-1:0] last;
    logic [SizeBits-1:0] size;
    logic [OwnBits-1:0]  owner;
    logic [1:0]          status;
  } alloc_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [1:0]          req_type_i = '0;
  logic [SizeBits-1:0] request_size_i = '0;
  logic [OwnBits-1:0]  owner_id_i = '0;
  logic [AddrBits-1:0] last_start_address_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [AddrBits-1:0] block_start_o;
  logic [AddrBits-1:0] block_end_o;
  logic [SizeBits-1:0] block_size_o;
  logic [OwnBits-1:0]  block_owner_o;
  logic [1:0]          status_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic                cfg_index_i = 1'b0;
  logic [SizeBits-1:0] cfg_data_i = '0;

  segment_table_allocator dut (.*);

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow of the segment table. Only entries below tbl_count are ever read.
  // ---------------------------------------------------------------------------
  logic [AddrBits-1:0] tbl_start [MapEntries];
  logic [AddrBits-1:0] tbl_last  [MapEntries];
  logic [SizeBits-1:0] tbl_size  [MapEntries];
  logic [OwnBits-1:0]  tbl_owner [MapEntries];
  int                  tbl_count = 0;
  logic [1:0]          cur_policy = PolFirst;
  logic [SizeBits-1:0] cur_mem_size = 17'd65536;

  alloc_result_t pending_results[$];
  int errors = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int full_hits = 0;
  int merges_seen = 0;

  // sender / receiver idling control
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int hold_seq = 0;

  function automatic void copy_entry(int dst, int src);
    tbl_start[dst] = tbl_start[src];
    tbl_last[dst]  = tbl_last[src];
    tbl_size[dst]  = tbl_size[src];
    tbl_owner[dst] = tbl_owner[src];
  endfunction

  function automatic void drop_entries(int pos, int n);
    for (int i = pos; i + n < tbl_count; i++) copy_entry(i, i + n);
    tbl_count -= n;
  endfunction

  function automatic bit seg_fits(int i, logic [SizeBits-1:0] req);
    return tbl_owner[i] == '0 && tbl_size[i] >= req;
  endfunction

  // index of the free segment the current policy picks, -1 if none
  function automatic int pick_segment(logic [SizeBits-1:0] req, logic [AddrBits-1:0] from);
    int pick;
    int base;
    pick = -1;
    base = -1;
    if (cur_policy == PolNext) begin
      // last matching start wins; search strictly after it, no wrap
      for (int i = 0; i < tbl_count; i++) if (tbl_start[i] == from) base = i;
      if (base < 0) return -1;
      for (int i = base + 1; i < tbl_count; i++) if (seg_fits(i, req)) return i;
      return -1;
    end
    for (int i = 0; i < tbl_count; i++) begin
      if (!seg_fits(i, req)) continue;
      if (pick < 0) begin
        pick = i;
        if (cur_policy == PolFirst) return pick;
      end else if (cur_policy == PolBest && tbl_size[i] < tbl_size[pick]) begin
        pick = i;
      end else if (cur_policy == PolWorst && tbl_size[i] > tbl_size[pick]) begin
        pick = i;
      end
    end
    return pick;
  endfunction

  function automatic void allocate_segment(logic [SizeBits-1:0] req, logic [OwnBits-1:0] own,
                                           logic [AddrBits-1:0] from, ref alloc_result_t r);
    int idx;
    logic [SizeBits-1:0] sum;
    if (req == '0 || own == '0) begin
      r.status = StNoFit;
      return;
    end
    idx = pick_segment(req, from);
    if (idx < 0) begin
      r.status = StNoFit;
      return;
    end
    if (tbl_size[idx] != req) begin
      if (tbl_count >= MapEntries) begin
        r.status = StFull;
        full_hits++;
        return;
      end
      for (int i = tbl_count; i > idx + 1; i--) copy_entry(i, i - 1);
      sum = {1'b0, tbl_start[idx]} + req;
      tbl_start[idx+1] = sum[AddrBits-1:0];
      tbl_last[idx+1]  = tbl_last[idx];
      tbl_size[idx+1]  = tbl_size[idx] - req;
      tbl_owner[idx+1] = '0;
      sum = sum - 1'b1;
      tbl_last[idx] = sum[AddrBits-1:0];
      tbl_size[idx] = req;
      tbl_count++;
    end
    tbl_owner[idx] = own;
    r.start  = tbl_start[idx];
    r.last   = tbl_last[idx];
    r.size   = tbl_size[idx];
    r.owner  = own;
    r.status = StDone;
  endfunction

  function automatic logic [1:0] release_segment(logic [OwnBits-1:0] own);
    int idx;
    bit left_free;
    bit right_free;
    idx = -1;
    if (own == '0) return StNotFound;
    for (int i = 0; i < tbl_count; i++) if (tbl_owner[i] == own) begin
      idx = i;
      break;
    end
    if (idx < 0) return StNotFound;
    // a missing neighbour is treated as owned
    left_free  = idx > 0 && tbl_owner[idx-1] == '0;
    right_free = idx + 1 < tbl_count && tbl_owner[idx+1] == '0;
    if (left_free || right_free) merges_seen++;
    if (left_free && right_free) begin
      tbl_last[idx-1] = tbl_last[idx+1];
      tbl_size[idx-1] = tbl_size[idx-1] + tbl_size[idx] + tbl_size[idx+1];
      drop_entries(idx, 2);
    end else if (left_free) begin
      tbl_last[idx-1] = tbl_last[idx];
      tbl_size[idx-1] = tbl_size[idx-1] + tbl_size[idx];
      drop_entries(idx, 1);
    end else if (right_free) begin
      tbl_last[idx]  = tbl_last[idx+1];
      tbl_size[idx]  = tbl_size[idx] + tbl_size[idx+1];
      tbl_owner[idx] = '0;
      drop_entries(idx + 1, 1);
    end else begin
      tbl_owner[idx] = '0;
    end
    return StDone;
  endfunction

  function automatic void init_table();
    logic [SizeBits-1:0] sz;
    // anything past the address space saturates to 2^AddrBits words
    sz = (cur_mem_size > 17'd65536) ? 17'd65536 : cur_mem_size;
    if (sz == '0) begin
      tbl_count = 0;
      return;
    end
    tbl_start[0] = '0;
    tbl_last[0]  = AddrBits'(sz - 1'b1);
    tbl_size[0]  = sz;
    tbl_owner[0] = '0;
    tbl_count = 1;
  endfunction

  function automatic alloc_result_t predict_request(logic [1:0] kind, logic [SizeBits-1:0] req,
                                                    logic [OwnBits-1:0] own,
                                                    logic [AddrBits-1:0] from);
    alloc_result_t r;
    r = '{default: '0};
    r.status = StDone;
    case (kind)
      ReqAlloc:   allocate_segment(req, own, from, r);
      ReqRelease: r.status = release_segment(own);
      ReqInit:    init_table();
      default:    ;  // unused request code: no change
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver. Valid is left high on return; idle_gap() may lower it, stop_sending() does.
  // ---------------------------------------------------------------------------
  task automatic send_request(logic [1:0] kind, logic [SizeBits-1:0] req,
                              logic [OwnBits-1:0] own, logic [AddrBits-1:0] from);
    in_valid_i           <= 1'b1;
    req_type_i           <= kind;
    request_size_i       <= req;
    owner_id_i           <= own;
    last_start_address_i <= from;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(predict_request(kind, req, own, from));
    requests_sent++;
  endtask

  task automatic idle_gap();
    int n;
    int r;
    r = $urandom_range(99);
    if (tx_calm || r < 60) n = 0;
    else if (r < 95) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    stop_sending();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // config writes only with the block idle
  task automatic write_config(logic idx, logic [SizeBits-1:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgPolicy) cur_policy = data[1:0];
    else cur_mem_size = data;
  endtask

  // random request biased toward well-formed traffic over live segments
  task automatic random_request();
    int r;
    int k;
    int lim;
    logic [SizeBits-1:0] sz;
    logic [OwnBits-1:0] own;
    logic [AddrBits-1:0] from;
    r = $urandom_range(99);
    from = AddrBits'($urandom);
    if (tbl_count > 0 && $urandom_range(9) < 8)
      from = tbl_start[$urandom_range(tbl_count - 1)];
    if (r < 55) begin
      lim = (cur_mem_size > 17'd32) ? int'(cur_mem_size) / 24 : 2;
      if ($urandom_range(19) == 0) sz = SizeBits'($urandom);
      else sz = SizeBits'($urandom_range(1, lim));
      own = ($urandom_range(29) == 0) ? '0 : OwnBits'($urandom_range(1, 255));
      send_request(ReqAlloc, sz, own, from);
    end else if (r < 92) begin
      own = OwnBits'($urandom);
      if (tbl_count > 0 && $urandom_range(9) < 8) begin
        k = $urandom_range(tbl_count - 1);
        if (tbl_owner[k] != '0) own = tbl_owner[k];
      end
      send_request(ReqRelease, SizeBits'($urandom), own, from);
    end else if (r < 96) begin
      send_request(ReqInit, SizeBits'($urandom), OwnBits'($urandom), from);
    end else begin
      // unused request code with noise on every field
      send_request(ReqUnused, SizeBits'($urandom), OwnBits'($urandom), from);
    end
    idle_gap();
  endtask

  // ---------------------------------------------------------------------------
  // Result checker and receiver stall pattern
  // ---------------------------------------------------------------------------
  int hold_left = 0;
  int stall_left = 0;
  int hold_seen = 0;

  task automatic check_result();
    alloc_result_t e;
    results_seen++;
    if (pending_results.size() == 0) begin
      $error("result with nothing expected: start %0d status %0d", block_start_o, status_o);
      errors++;
      return;
    end
    e = pending_results.pop_front();
    if (block_start_o !== e.start) begin
      $error("block_start expected %0d actual %0d", e.start, block_start_o);
      errors++;
    end
    if (block_end_o !== e.last) begin
      $error("block_end expected %0d actual %0d", e.last, block_end_o);
      errors++;
    end
    if (block_size_o !== e.size) begin
      $error("block_size expected %0d actual %0d", e.size, block_size_o);
      errors++;
    end
    if (block_owner_o !== e.owner) begin
      $error("block_owner expected %0d actual %0d", e.owner, block_owner_o);
      errors++;
    end
    if (status_o !== e.status) begin
      $error("status expected %0d actual %0d", e.status, status_o);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result();
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!rx_calm && $urandom_range(99) < 25) begin
      // mostly short stalls, now and then a long one
      stall_left = ($urandom_range(19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // watchdog: cycles without any handshake
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= IdleLimit) begin
      $display("watchdog: %0d cycles without progress", IdleLimit);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // corner requests: empty table, full-memory block, zero size/owner, odd codes
  task automatic test_corner_requests();
    send_request(ReqAlloc, 17'd5, 8'd1, 16'd0);         // empty table: no fit
    send_request(ReqRelease, '0, 8'd1, 16'd0);          // empty table: not found
    send_request(ReqUnused, '1, '1, '1);                // unused code ignored
    send_request(ReqInit, '0, '0, '0);                  // reset-value memory size
    send_request(ReqAlloc, 17'd0, 8'd7, 16'd0);         // zero size refused
    send_request(ReqAlloc, 17'd10, 8'd0, 16'd0);        // zero owner refused
    send_request(ReqAlloc, 17'd65536, 8'd255, 16'hffff); // exact fit of all memory
    send_request(ReqAlloc, 17'd1, 8'd2, 16'd0);         // nothing free
    send_request(ReqRelease, '0, 8'd0, 16'd0);          // owner zero never released
    send_request(ReqRelease, '0, 8'd255, 16'd0);
    send_request(ReqAlloc, 17'h1ffff, 8'd3, 16'd0);     // larger than memory
    idle_gap();
    write_config(CfgMemSize, 17'd0);
    send_request(ReqInit, '0, '0, '0);                  // empty table
    send_request(ReqAlloc, 17'd1, 8'd1, 16'd0);
    write_config(CfgMemSize, 17'h1ffff);                // saturates
    send_request(ReqInit, '0, '0, '0);
    send_request(ReqAlloc, 17'd65535, 8'h80, 16'd0);
    send_request(ReqAlloc, 17'd1, 8'h01, 16'd0);
    send_request(ReqRelease, '0, 8'h80, 16'd0);         // right neighbour owned
    send_request(ReqRelease, '0, 8'h01, 16'd0);         // merges left
    write_config(CfgMemSize, 17'd1);
    send_request(ReqInit, '0, '0, '0);
    send_request(ReqAlloc, 17'd1, 8'd9, 16'd0);
    send_request(ReqRelease, '0, 8'd9, 16'd0);
  endtask

  // split single words off until the table has no room for another split
  task automatic test_table_full();
    write_config(CfgPolicy, PolFirst);
    write_config(CfgMemSize, 17'd100);
    send_request(ReqInit, '0, '0, '0);
    for (int i = 0; i < 66; i++) begin
      send_request(ReqAlloc, 17'd1, OwnBits'(i % 255 + 1), 16'd0);
      idle_gap();
    end
    send_request(ReqAlloc, 17'd37, 8'd200, 16'd0);     // exact fit still allowed
    // free alternate owners, then both-sided merges
    for (int i = 1; i < 64; i += 2) send_request(ReqRelease, '0, OwnBits'(i), 16'd0);
    for (int i = 2; i < 64; i += 2) send_request(ReqRelease, '0, OwnBits'(i), 16'd0);
    idle_gap();
  endtask

  task automatic test_policy(logic [1:0] pol, logic [SizeBits-1:0] mem, int count);
    write_config(CfgPolicy, pol);
    write_config(CfgMemSize, mem);
    send_request(ReqInit, '0, '0, '0);
    for (int i = 0; i < count; i++) begin
      // alternate calm and noisy stretches on both sides
      tx_calm = (i / 40) % 3 == 1;
      rx_calm = (i / 40) % 3 == 1;
      random_request();
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  // receiver holds off while requests keep coming, then the sender waits dry
  task automatic test_backpressure();
    write_config(CfgPolicy, PolBest);
    write_config(CfgMemSize, 17'd2048);
    send_request(ReqInit, '0, '0, '0);
    hold_seq++;
    for (int i = 0; i < 20; i++) random_request();
    drain();
    for (int i = 0; i < 10; i++) random_request();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_requests();
    test_table_full();
    test_policy(PolFirst, 17'd4096, 180);
    test_policy(PolBest, 17'd512, 180);
    test_policy(PolWorst, 17'd65536, 180);
    test_policy(PolNext, 17'd1024, 180);
    test_policy(PolNext, 17'd300, 60);
    test_backpressure();
    drain();
    repeat (SettleWait) @(posedge clk_i);
    $display("%0d requests, %0d results checked; all four fit policies, %0d table-full",
             requests_sent, results_seen, full_hits);
    $display("refusals and %0d merging releases exercised", merges_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
